// ===== src/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg: shared definitions for the 3-vector fixed-point ALU
// Word format, derived datapath widths, opcodes, status codes and the
// side-band record that rides along the root and divide pipelines.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int PROD_BITS = 2 * WORD_BITS;       // full product / sum of squares
    localparam int VAL_BITS  = 2 * WORD_BITS + 3;   // signed pre-rounding value
    localparam int ROOT_BITS = WORD_BITS;           // floor square root
    localparam int SREM_BITS = WORD_BITS + 3;       // square-root partial remainder
    localparam int DIVR_BITS = WORD_BITS + 1;       // divisor (rounded magnitude or scalar magnitude)
    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS; // dividend / quotient

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_NEG   = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_DOT   = 4'd5;
    localparam logic [3:0] OP_CROSS = 4'd6;
    localparam logic [3:0] OP_MAG   = 4'd7;
    localparam logic [3:0] OP_MAGSQ = 4'd8;
    localparam logic [3:0] OP_NORM  = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_ZNORM = 2'd3;

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic [3:0]                  op;
        logic [2:0][WORD_BITS-1:0]   a;
        logic [WORD_BITS-1:0]        s;
        logic [2:0][WORD_BITS-1:0]   early;
        logic                        early_ovf;
    } t_side;

endpackage

// ===== src/vec3_fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu: pipelined 3-vector ALU in signed fixed point
// Add, subtract, negate, scale, divide, dot, cross, magnitude, magnitude
// squared and normalize, rounded to nearest and saturated to the word range.
// ----------------------------------------------------------------------------
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------------------
//  in      | i_valid | o_ready | i_opcode, i_a_*, i_b_*, i_scalar_in
//  out     | o_valid | i_ready | o_r_x, o_r_y, o_r_z, o_status
//
//  One transfer per cycle in and out while the output is not stalled.
//  88 register stages: 5 front stages (capture, multiply, sum, round,
//  saturate), 32 square-root stages (one root bit each), 2 divisor set-up
//  stages, 48 restoring-divide stages (one quotient bit each), 1 output
//  stage. Reset clears the valid bits only. A stall at the output freezes
//  the whole pipe; o_ready drops only while a result waits and i_ready is
//  low.
//
module vec3_fixed_point_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3:0]        i_opcode,
    input  v3alu_pkg::t_word  i_a_x,
    input  v3alu_pkg::t_word  i_a_y,
    input  v3alu_pkg::t_word  i_a_z,
    input  v3alu_pkg::t_word  i_b_x,
    input  v3alu_pkg::t_word  i_b_y,
    input  v3alu_pkg::t_word  i_b_z,
    input  v3alu_pkg::t_word  i_scalar_in,
    output logic              o_valid,
    input  logic              i_ready,
    output v3alu_pkg::t_word  o_r_x,
    output v3alu_pkg::t_word  o_r_y,
    output v3alu_pkg::t_word  o_r_z,
    output logic [1:0]        o_status
);

    localparam int W    = v3alu_pkg::WORD_BITS;
    localparam int F    = v3alu_pkg::FRAC_BITS;
    localparam int PW   = v3alu_pkg::PROD_BITS;
    localparam int VW   = v3alu_pkg::VAL_BITS;
    localparam int RW   = v3alu_pkg::ROOT_BITS;
    localparam int SRW  = v3alu_pkg::SREM_BITS;
    localparam int DW   = v3alu_pkg::DIVR_BITS;
    localparam int NW   = v3alu_pkg::QUO_BITS;
    localparam int S2W  = W + 2;
    localparam int RDW  = VW - F + 1;

    localparam logic [W-1:0]   MAXW     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MINW     = {1'b1, {(W-1){1'b0}}};
    localparam logic [VW:0]    RHALF    = (VW+1)'(1) << (F-1);
    localparam logic [RDW-1:0] LIM_RPOS = {{(RDW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [RDW-1:0] LIM_RNEG = LIM_RPOS + RDW'(1);
    localparam logic [NW-1:0]  LIM_QPOS = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NW-1:0]  LIM_QNEG = LIM_QPOS + NW'(1);
    localparam logic [DW-1:0]  LIM_MAG  = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};

    // whole pipe advances together; o_ready follows i_ready combinationally while a result waits
    logic adv;
    logic r_out_v;
    assign adv     = !r_out_v || i_ready;
    assign o_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: capture
    // ------------------------------------------------------------------
    logic                  r1_v;
    logic [3:0]            r1_op;
    v3alu_pkg::t_word      r1_a [3];
    v3alu_pkg::t_word      r1_b [3];
    v3alu_pkg::t_word      r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_op   <= i_opcode;
            r1_a[0] <= i_a_x;
            r1_a[1] <= i_a_y;
            r1_a[2] <= i_a_z;
            r1_b[0] <= i_b_x;
            r1_b[1] <= i_b_y;
            r1_b[2] <= i_b_z;
            r1_s    <= i_scalar_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: six multipliers and the plain component sums.
    // Lane i second product is only used by cross.
    // ------------------------------------------------------------------
    v3alu_pkg::t_word        m0a [3];
    v3alu_pkg::t_word        m0b [3];
    v3alu_pkg::t_word        m1a [3];
    v3alu_pkg::t_word        m1b [3];
    logic signed [S2W-1:0]   n2_sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m0a[i]    = '0;
            m0b[i]    = '0;
            m1a[i]    = '0;
            m1b[i]    = '0;
            n2_sum[i] = '0;
            case (r1_op)
                v3alu_pkg::OP_ADD: begin
                    n2_sum[i] = S2W'(r1_a[i]) + S2W'(r1_b[i]);
                end
                v3alu_pkg::OP_SUB: begin
                    n2_sum[i] = S2W'(r1_a[i]) - S2W'(r1_b[i]);
                end
                v3alu_pkg::OP_NEG: begin
                    n2_sum[i] = S2W'(0) - S2W'(r1_a[i]);
                end
                v3alu_pkg::OP_SCALE: begin
                    m0a[i] = r1_a[i];
                    m0b[i] = r1_s;
                end
                v3alu_pkg::OP_DOT: begin
                    m0a[i] = r1_a[i];
                    m0b[i] = r1_b[i];
                end
                v3alu_pkg::OP_CROSS: begin
                    m0a[i] = r1_a[(i == 2) ? 0 : i + 1];
                    m0b[i] = r1_b[(i == 0) ? 2 : i - 1];
                    m1a[i] = r1_a[(i == 0) ? 2 : i - 1];
                    m1b[i] = r1_b[(i == 2) ? 0 : i + 1];
                end
                v3alu_pkg::OP_MAG, v3alu_pkg::OP_MAGSQ, v3alu_pkg::OP_NORM: begin
                    m0a[i] = r1_a[i];
                    m0b[i] = r1_a[i];
                end
                default: ;
            endcase
        end
    end

    logic                  r2_v;
    logic [3:0]            r2_op;
    v3alu_pkg::t_word      r2_a [3];
    v3alu_pkg::t_word      r2_s;
    logic signed [PW-1:0]  r2_p0 [3];
    logic signed [PW-1:0]  r2_p1 [3];
    logic signed [S2W-1:0] r2_sum [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_op <= r1_op;
            r2_s  <= r1_s;
            for (int i = 0; i < 3; i++) begin
                r2_a[i]   <= r1_a[i];
                r2_p0[i]  <= PW'(m0a[i]) * PW'(m0b[i]);
                r2_p1[i]  <= PW'(m1a[i]) * PW'(m1b[i]);
                r2_sum[i] <= n2_sum[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: form exact signed value per lane and the sum of squares
    // ------------------------------------------------------------------
    logic signed [VW-1:0] sum3;
    logic signed [VW-1:0] n3_v [3];

    always_comb begin
        sum3 = VW'(r2_p0[0]) + VW'(r2_p0[1]) + VW'(r2_p0[2]);
        for (int i = 0; i < 3; i++) begin
            case (r2_op)
                v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_NEG: begin
                    // pre-shift so the shared rounding step is exact
                    n3_v[i] = VW'(r2_sum[i]) <<< F;
                end
                v3alu_pkg::OP_SCALE: n3_v[i] = VW'(r2_p0[i]);
                v3alu_pkg::OP_DOT, v3alu_pkg::OP_MAGSQ: begin
                    n3_v[i] = (i == 0) ? sum3 : '0;
                end
                v3alu_pkg::OP_CROSS: n3_v[i] = VW'(r2_p0[i]) - VW'(r2_p1[i]);
                default: n3_v[i] = '0;
            endcase
        end
    end

    logic                 r3_v;
    logic [3:0]           r3_op;
    v3alu_pkg::t_word     r3_a [3];
    v3alu_pkg::t_word     r3_s;
    logic signed [VW-1:0] r3_val [3];
    logic [PW-1:0]        r3_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_op <= r2_op;
            r3_s  <= r2_s;
            r3_sq <= PW'(sum3);
            for (int i = 0; i < 3; i++) begin
                r3_a[i]   <= r2_a[i];
                r3_val[i] <= n3_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round magnitude to nearest, ties away from zero
    // ------------------------------------------------------------------
    logic [VW-1:0]  s4_mag [3];
    logic [VW:0]    s4_tmp [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s4_mag[i] = r3_val[i][VW-1] ? VW'(-r3_val[i]) : VW'(r3_val[i]);
            s4_tmp[i] = {1'b0, s4_mag[i]} + RHALF;
        end
    end

    logic               r4_v;
    logic [3:0]         r4_op;
    v3alu_pkg::t_word   r4_a [3];
    v3alu_pkg::t_word   r4_s;
    logic [PW-1:0]      r4_sq;
    logic               r4_neg [3];
    logic [RDW-1:0]     r4_rnd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_op <= r3_op;
            r4_s  <= r3_s;
            r4_sq <= r3_sq;
            for (int i = 0; i < 3; i++) begin
                r4_a[i]   <= r3_a[i];
                r4_neg[i] <= r3_val[i][VW-1];
                r4_rnd[i] <= s4_tmp[i][VW:F];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: saturate to word, build side-band record
    // ------------------------------------------------------------------
    v3alu_pkg::t_side n5_side;
    logic             s5_ovf [3];

    always_comb begin
        n5_side.op        = r4_op;
        n5_side.s         = r4_s;
        n5_side.early_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n5_side.a[i] = r4_a[i];
            s5_ovf[i]    = r4_rnd[i] > (r4_neg[i] ? LIM_RNEG : LIM_RPOS);
            if (s5_ovf[i]) begin
                n5_side.early[i] = r4_neg[i] ? MINW : MAXW;
            end else if (r4_neg[i]) begin
                n5_side.early[i] = W'(0) - r4_rnd[i][W-1:0];
            end else begin
                n5_side.early[i] = r4_rnd[i][W-1:0];
            end
            n5_side.early_ovf = n5_side.early_ovf | s5_ovf[i];
        end
    end

    logic             r5_v;
    v3alu_pkg::t_side r5_side;
    logic [PW-1:0]    r5_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_side <= n5_side;
            r5_sq   <= r4_sq;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage, two radicand bits consumed each
    // ------------------------------------------------------------------
    logic             r_sq_v    [RW];
    v3alu_pkg::t_side r_sq_side [RW];
    logic [SRW-1:0]   r_sq_rem  [RW];
    logic [RW-1:0]    r_sq_root [RW];
    logic [PW-1:0]    r_sq_src  [RW];

    logic [SRW-1:0]   n_sq_rem  [RW];
    logic [RW-1:0]    n_sq_root [RW];
    logic [PW-1:0]    n_sq_src  [RW];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            logic [SRW-1:0] rin;
            logic [SRW-1:0] rx;
            logic [SRW-1:0] t;
            logic [RW-1:0]  root_in;
            logic [PW-1:0]  src_in;
            if (k == 0) begin
                rin     = '0;
                root_in = '0;
                src_in  = r5_sq;
            end else begin
                rin     = r_sq_rem[k-1];
                root_in = r_sq_root[k-1];
                src_in  = r_sq_src[k-1];
            end
            rx = {rin[SRW-3:0], src_in[PW-1 -: 2]};
            t  = SRW'({root_in, 2'b01});
            if (rx >= t) begin
                n_sq_rem[k]  = rx - t;
                n_sq_root[k] = {root_in[RW-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = rx;
                n_sq_root[k] = {root_in[RW-2:0], 1'b0};
            end
            n_sq_src[k] = src_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                r_sq_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_sq_v[0] <= r5_v;
            for (int k = 1; k < RW; k++) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_side[0] <= r5_side;
            for (int k = 1; k < RW; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
            for (int k = 0; k < RW; k++) begin
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_src[k]  <= n_sq_src[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divisor set-up: round the root, then pick divisor and bias dividend
    // ------------------------------------------------------------------
    logic             r_m1_v;
    v3alu_pkg::t_side r_m1_side;
    logic [DW-1:0]    r_m1_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (adv) begin
            r_m1_v <= r_sq_v[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1_side <= r_sq_side[RW-1];
            r_m1_mag  <= DW'(r_sq_root[RW-1])
                       + DW'(r_sq_rem[RW-1] > SRW'(r_sq_root[RW-1]));
        end
    end

    logic [W-1:0]   s_abs;
    logic [W-1:0]   a_abs [3];
    logic [DW-1:0]  n_m2_d;
    logic [NW-1:0]  n_m2_n [3];

    always_comb begin
        s_abs  = r_m1_side.s[W-1] ? W'(0) - r_m1_side.s : r_m1_side.s;
        n_m2_d = (r_m1_side.op == v3alu_pkg::OP_DIV) ? DW'(s_abs) : r_m1_mag;
        for (int i = 0; i < 3; i++) begin
            a_abs[i]  = r_m1_side.a[i][W-1] ? W'(0) - r_m1_side.a[i] : r_m1_side.a[i];
            n_m2_n[i] = (NW'(a_abs[i]) << F) + NW'(n_m2_d >> 1);
        end
    end

    logic             r_m2_v;
    v3alu_pkg::t_side r_m2_side;
    logic [DW-1:0]    r_m2_mag;
    logic [DW-1:0]    r_m2_d;
    logic [NW-1:0]    r_m2_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (adv) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m2_side <= r_m1_side;
            r_m2_mag  <= r_m1_mag;
            r_m2_d    <= n_m2_d;
            for (int i = 0; i < 3; i++) begin
                r_m2_n[i] <= n_m2_n[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring divide: three lanes, one quotient bit per stage
    // ------------------------------------------------------------------
    logic             r_dv_v    [NW];
    v3alu_pkg::t_side r_dv_side [NW];
    logic [DW-1:0]    r_dv_mag  [NW];
    logic [DW-1:0]    r_dv_d    [NW];
    logic [NW-1:0]    r_dv_q    [NW][3];
    logic [DW-1:0]    r_dv_rem  [NW][3];
    logic [NW-1:0]    r_dv_src  [NW][3];

    logic [NW-1:0]    n_dv_q    [NW][3];
    logic [DW-1:0]    n_dv_rem  [NW][3];
    logic [NW-1:0]    n_dv_src  [NW][3];

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            for (int i = 0; i < 3; i++) begin
                logic [DW-1:0] rin;
                logic [NW-1:0] q_in;
                logic [NW-1:0] src_in;
                logic [DW-1:0] d;
                logic [DW:0]   rx;
                logic [DW:0]   diff;
                if (k == 0) begin
                    rin    = '0;
                    q_in   = '0;
                    src_in = r_m2_n[i];
                    d      = r_m2_d;
                end else begin
                    rin    = r_dv_rem[k-1][i];
                    q_in   = r_dv_q[k-1][i];
                    src_in = r_dv_src[k-1][i];
                    d      = r_dv_d[k-1];
                end
                rx   = {rin, src_in[NW-1]};
                diff = rx - {1'b0, d};
                if (rx >= {1'b0, d}) begin
                    n_dv_rem[k][i] = diff[DW-1:0];
                    n_dv_q[k][i]   = {q_in[NW-2:0], 1'b1};
                end else begin
                    n_dv_rem[k][i] = rx[DW-1:0];
                    n_dv_q[k][i]   = {q_in[NW-2:0], 1'b0};
                end
                n_dv_src[k][i] = src_in << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_dv_v[0] <= r_m2_v;
            for (int k = 1; k < NW; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_side[0] <= r_m2_side;
            r_dv_mag[0]  <= r_m2_mag;
            r_dv_d[0]    <= r_m2_d;
            for (int k = 1; k < NW; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
                r_dv_mag[k]  <= r_dv_mag[k-1];
                r_dv_d[k]    <= r_dv_d[k-1];
            end
            for (int k = 0; k < NW; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_q[k][i]   <= n_dv_q[k][i];
                    r_dv_rem[k][i] <= n_dv_rem[k][i];
                    r_dv_src[k][i] <= n_dv_src[k][i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result select and output register
    // ------------------------------------------------------------------
    v3alu_pkg::t_side fs;
    logic [W-1:0]     n_res [3];
    logic [1:0]       n_status;
    logic             q_ovf [3];
    logic             any_ovf;
    logic             q_neg;
    logic [NW-1:0]    q;
    logic             s_zero;
    logic             m_zero;

    always_comb begin
        fs      = r_dv_side[NW-1];
        s_zero  = (fs.s == '0);
        m_zero  = (r_dv_mag[NW-1] == '0);
        any_ovf = 1'b0;
        q_neg   = 1'b0;
        q       = '0;
        for (int i = 0; i < 3; i++) begin
            q_ovf[i] = 1'b0;
            q        = r_dv_q[NW-1][i];
            q_neg    = fs.a[i][W-1] ^ ((fs.op == v3alu_pkg::OP_DIV) & fs.s[W-1]);
            case (fs.op)
                v3alu_pkg::OP_DIV, v3alu_pkg::OP_NORM: begin
                    if (fs.op == v3alu_pkg::OP_DIV && s_zero) begin
                        // divide by zero: saturate by the sign of a
                        if (fs.a[i] == '0) begin
                            n_res[i] = '0;
                        end else begin
                            n_res[i] = fs.a[i][W-1] ? MINW : MAXW;
                        end
                    end else if (fs.op == v3alu_pkg::OP_NORM && m_zero) begin
                        n_res[i] = '0;
                    end else begin
                        q_ovf[i] = q > (q_neg ? LIM_QNEG : LIM_QPOS);
                        if (q_ovf[i]) begin
                            n_res[i] = q_neg ? MINW : MAXW;
                        end else if (q_neg) begin
                            n_res[i] = W'(0) - q[W-1:0];
                        end else begin
                            n_res[i] = q[W-1:0];
                        end
                    end
                end
                v3alu_pkg::OP_MAG: begin
                    if (i != 0) begin
                        n_res[i] = '0;
                    end else if (r_dv_mag[NW-1] > LIM_MAG) begin
                        q_ovf[i] = 1'b1;
                        n_res[i] = MAXW;
                    end else begin
                        n_res[i] = r_dv_mag[NW-1][W-1:0];
                    end
                end
                default: n_res[i] = fs.early[i];
            endcase
            any_ovf = any_ovf | q_ovf[i];
        end

        if (fs.op == v3alu_pkg::OP_DIV && s_zero) begin
            n_status = v3alu_pkg::ST_DIV0;
        end else if (fs.op == v3alu_pkg::OP_NORM && m_zero) begin
            n_status = v3alu_pkg::ST_ZNORM;
        end else if (any_ovf || fs.early_ovf) begin
            n_status = v3alu_pkg::ST_OVF;
        end else begin
            n_status = v3alu_pkg::ST_OK;
        end
    end

    logic [W-1:0] r_out_x;
    logic [W-1:0] r_out_y;
    logic [W-1:0] r_out_z;
    logic [1:0]   r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_dv_v[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x  <= n_res[0];
            r_out_y  <= n_res[1];
            r_out_z  <= n_res[2];
            r_out_st <= n_status;
        end
    end

    assign o_valid  = r_out_v;
    assign o_r_x    = r_out_x;
    assign o_r_y    = r_out_y;
    assign o_r_z    = r_out_z;
    assign o_status = r_out_st;

endmodule

// ===== src/v3alu_checker.sv =====
// ----------------------------------------------------------------------------
// v3alu_checker: port-level checks for the 3-vector ALU
// Watches the output channel and the status-coded special results.
// ----------------------------------------------------------------------------
module v3alu_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input v3alu_pkg::t_word  o_r_x,
    input v3alu_pkg::t_word  o_r_y,
    input v3alu_pkg::t_word  o_r_z,
    input logic [1:0]        o_status
);

    localparam int W = v3alu_pkg::WORD_BITS;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_r_x) && $stable(o_r_y)
                                && $stable(o_r_z) && $stable(o_status))
        else $error("output transfer changed while stalled");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    a_znorm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == v3alu_pkg::ST_ZNORM |->
            o_r_x == '0 && o_r_y == '0 && o_r_z == '0)
        else $error("zero-vector normalize gave nonzero result");

    a_div0_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == v3alu_pkg::ST_DIV0 |->
            (o_r_x == '0 || o_r_x == MAXW || o_r_x == MINW) &&
            (o_r_y == '0 || o_r_y == MAXW || o_r_y == MINW) &&
            (o_r_z == '0 || o_r_z == MAXW || o_r_z == MINW))
        else $error("divide by zero result not saturated");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind vec3_fixed_point_alu v3alu_checker u_v3alu_checker (.*);
